// ===== rtl/core/tcr_pkg.sv =====
// Shared types, constants and decode functions for the text console renderer.
// No dependencies; every other file of the block imports this package.
package tcr_pkg;

	// Default geometry and sizes handed down from the top level.
	localparam int CELL_W_DEF      = 6;
	localparam int CELL_H_DEF      = 10;
	localparam int STACK_DEPTH_DEF = 8;
	localparam int GLYPH_COUNT_DEF = 96;

	// Stream and configuration port widths.
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_BASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COLUMNS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TEXT_ROWS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_MASK     = 3'd4;

	// Text byte codes.
	localparam logic [7:0] CODE_FORE_FIRST  = 8'd1;
	localparam logic [7:0] CODE_FORE_LAST   = 8'd8;
	localparam logic [7:0] CODE_HALF_FORE   = 8'd9;
	localparam logic [7:0] CODE_NEWLINE     = 8'd10;
	localparam logic [7:0] CODE_PUSH        = 8'd11;
	localparam logic [7:0] CODE_POP         = 8'd12;
	localparam logic [7:0] CODE_BACK_FIRST  = 8'd17;
	localparam logic [7:0] CODE_BACK_LAST   = 8'd24;
	localparam logic [7:0] CODE_HALF_BACK   = 8'd25;
	localparam logic [7:0] CODE_PRINT_FIRST = 8'd32;
	localparam logic [7:0] CODE_PRINT_LAST  = 8'd127;

	// RGB565 palette.
	localparam logic [15:0] RGB_RED     = 16'b1111100000000000;
	localparam logic [15:0] RGB_GREEN   = 16'b0000011111100000;
	localparam logic [15:0] RGB_BLUE    = 16'b0000000000011111;
	localparam logic [15:0] RGB_YELLOW  = 16'b1111111111100000;
	localparam logic [15:0] RGB_MAGENTA = 16'b1111100000011111;
	localparam logic [15:0] RGB_CYAN    = 16'b0000011111111111;
	localparam logic [15:0] RGB_WHITE   = 16'b1111111111111111;
	localparam logic [15:0] RGB_BLACK   = 16'h0000;
	localparam logic [15:0] FORE_RESET  = 16'hffff;

	// Configuration register file contents.
	typedef struct packed {
		logic [31:0] screen_base;
		logic [15:0] line_pitch;
		logic [9:0]  max_columns;
		logic [9:0]  max_text_rows;
		logic [15:0] half_mask;
	} cfg_t;

	// What a text byte does.
	typedef enum logic [2:0] {
		CK_FORE,
		CK_BACK,
		CK_HALF_FORE,
		CK_HALF_BACK,
		CK_NEWLINE,
		CK_PUSH,
		CK_POP,
		CK_DRAW
	} code_kind_t;

	// Shared arithmetic unit request.
	typedef enum logic {
		OP_MUL,
		OP_ADD
	} arith_op_t;

	typedef struct packed {
		logic        en;
		arith_op_t   op;
		logic [31:0] a;
		logic [31:0] b;
	} arith_req_t;

	// Text byte handed to the colour unit.
	typedef struct packed {
		logic       en;
		logic [7:0] code;
	} colour_cmd_t;

	// Classify a text byte.
	function automatic code_kind_t code_kind(input logic [7:0] ch);
		code_kind_t k;
		case (ch) inside
			[CODE_FORE_FIRST:CODE_FORE_LAST]: k = CK_FORE;
			[CODE_BACK_FIRST:CODE_BACK_LAST]: k = CK_BACK;
			CODE_HALF_FORE:                   k = CK_HALF_FORE;
			CODE_HALF_BACK:                   k = CK_HALF_BACK;
			CODE_NEWLINE:                     k = CK_NEWLINE;
			CODE_PUSH:                        k = CK_PUSH;
			CODE_POP:                         k = CK_POP;
			default:                          k = CK_DRAW;
		endcase
		return k;
	endfunction

	// Palette lookup for the colour setting codes.
	function automatic logic [15:0] colour_of(input logic [2:0] idx);
		logic [15:0] c;
		case (idx)
			3'd0:    c = RGB_RED;
			3'd1:    c = RGB_GREEN;
			3'd2:    c = RGB_BLUE;
			3'd3:    c = RGB_YELLOW;
			3'd4:    c = RGB_MAGENTA;
			3'd5:    c = RGB_CYAN;
			3'd6:    c = RGB_WHITE;
			default: c = RGB_BLACK;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/tcr_arith.sv =====
// Shared multiply/add unit of the text console renderer, with a registered result.
// Depends on tcr_pkg for the request type.
module tcr_arith import tcr_pkg::*; (
	input  logic        clk,
	input  arith_req_t  req,
	output logic [31:0] result
);

	logic [31:0] result_q;

	// One 16x16 multiply or one 32-bit add per enabled cycle; sums wrap.
	always_ff @(posedge clk) begin
		if (req.en) begin
			case (req.op)
				OP_MUL:  result_q <= 32'(req.a[15:0]) * 32'(req.b[15:0]);
				OP_ADD:  result_q <= req.a + req.b;
				default: result_q <= req.a;
			endcase
		end
	end

	assign result = result_q;

endmodule

// ===== rtl/core/tcr_glyph_mem.sv =====
// Glyph row store: one write port and one registered read port.
// Depends on tcr_pkg for the default depth and width.
module tcr_glyph_mem import tcr_pkg::*; #(
	parameter int DEPTH = GLYPH_COUNT_DEF * (CELL_H_DEF - 1),
	parameter int DW    = CELL_W_DEF - 1,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write when enabled and read every cycle; the read address is always in range.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/tcr_colour.sv =====
// Foreground/background colour registers and the colour stack.
// Depends on tcr_pkg for code decode and the palette.
module tcr_colour import tcr_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  colour_cmd_t cmd,
	input  logic [15:0] half_mask,
	output logic [15:0] fore,
	output logic [15:0] back
);

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int IW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [15:0]    fore_q;
	logic [15:0]    back_q;
	logic [SPW-1:0] sp_q;
	logic [31:0]    stack_q [STACK_DEPTH];

	code_kind_t     kind;
	logic [SPW-1:0] sp_dec;
	logic [31:0]    top_entry;

	// A push on a full stack lands on entry zero again.
	always_comb begin
		kind      = code_kind(cmd.code);
		sp_dec    = (sp_q != '0) ? sp_q - SPW'(1) : sp_q;
		top_entry = stack_q[sp_q[IW-1:0]];
	end

	// Apply colour codes; other codes leave the colours alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_q <= FORE_RESET;
			back_q <= RGB_BLACK;
			sp_q   <= SPW'(STACK_DEPTH);
			for (int i = 0; i < STACK_DEPTH; i++) begin
				stack_q[i] <= '0;
			end
		end else if (cmd.en) begin
			case (kind)
				CK_FORE:      fore_q <= colour_of(3'(cmd.code - CODE_FORE_FIRST));
				CK_BACK:      back_q <= colour_of(3'(cmd.code - CODE_BACK_FIRST));
				CK_HALF_FORE: fore_q <= (fore_q >> 1) & half_mask;
				CK_HALF_BACK: back_q <= (back_q >> 1) & half_mask;
				CK_PUSH: begin
					sp_q                   <= sp_dec;
					stack_q[sp_dec[IW-1:0]] <= {back_q, fore_q};
				end
				CK_POP: begin
					// An empty stack leaves the colours as they are.
					if (sp_q < SPW'(STACK_DEPTH)) begin
						fore_q <= top_entry[15:0];
						back_q <= top_entry[31:16];
						sp_q   <= sp_q + SPW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign fore = fore_q;
	assign back = back_q;

endmodule

// ===== rtl/core/tcr_seq.sv =====
// Sequencer of the text console renderer: input beats, cursor, cell walk, output register.
// Depends on tcr_pkg; drives tcr_arith, tcr_glyph_mem and tcr_colour.
module tcr_seq import tcr_pkg::*; #(
	parameter int CELL_W      = CELL_W_DEF,
	parameter int CELL_H      = CELL_H_DEF,
	parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
	localparam int GROWS      = CELL_H - 1,
	localparam int AW         = $clog2(GLYPH_COUNT * GROWS),
	localparam int GW         = CELL_W - 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	// Output stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	output logic                  m_tuser,
	// Shared arithmetic unit.
	output arith_req_t            areq,
	input  logic [31:0]           result,
	// Glyph store.
	output logic                  gm_we,
	output logic [AW-1:0]         gm_waddr,
	output logic [GW-1:0]         gm_wdata,
	output logic [AW-1:0]         gm_raddr,
	input  logic [GW-1:0]         gm_rdata,
	// Colour unit.
	output colour_cmd_t           ccmd,
	input  logic [15:0]           fore,
	input  logic [15:0]           back
);

	localparam int PXW = $clog2(CELL_W);
	localparam int RW  = $clog2(CELL_H);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GLOAD,
		ST_GWRITE,
		ST_MGLYPH,
		ST_MCOL,
		ST_MROW,
		ST_MPITCH,
		ST_ABASE,
		ST_ACOL,
		ST_PIX,
		ST_SCROLL
	} state_t;

	state_t      state_q;
	logic [9:0]  col_q;
	logic [9:0]  row_q;
	logic [PXW-1:0] px_q;
	logic [RW-1:0]  grow_q;
	logic [7:0]  glyph_q;
	logic [6:0]  gi_q;
	logic [3:0]  gr_q;
	logic [4:0]  gb_q;
	logic [AW-1:0] gbase_q;
	logic [15:0] col_off_q;
	logic [31:0] row_addr_q;
	logic        m_tvalid_q;
	logic        m_kind_q;
	logic        m_last_q;
	logic [31:0] m_addr_q;
	logic [15:0] m_colour_q;

	// Input fields, lowest bits first.
	logic [7:0] in_char;
	logic [6:0] in_gi;
	logic [3:0] in_gr;
	logic [4:0] in_gb;

	logic        accept;
	logic        load_out;
	logic        pix_fire;
	logic [9:0]  cols_eff;
	logic [9:0]  rows_eff;
	logic        row_adv;
	logic [9:0]  col_inc;
	logic        wrap_col;
	logic        px_last;
	logic        row_last;
	logic        cell_end;
	logic        scroll_after;
	logic [GW-1:0]  row_bits;
	logic [PXW-1:0] bit_idx;
	logic        lit;
	logic [RW-1:0]  rd_row;
	logic [7:0]  draw_glyph;
	logic        load_ok;

	assign in_char = s_tdata[7:0];
	assign in_gi   = s_tdata[14:8];
	assign in_gr   = s_tdata[18:15];
	assign in_gb   = s_tdata[23:19];

	// Handshakes and cursor tests.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		accept   = s_tvalid && s_tready;
		load_out = !m_tvalid_q || m_tready;
		pix_fire = (state_q == ST_PIX) && load_out;

		cols_eff = (cfg.max_columns == '0) ? 10'd1 : cfg.max_columns;
		rows_eff = (cfg.max_text_rows == '0) ? 10'd1 : cfg.max_text_rows;
		row_adv  = ({1'b0, row_q} + 11'd1) < {1'b0, rows_eff};
		col_inc  = col_q + 10'd1;
		wrap_col = col_inc >= cols_eff;

		px_last      = (px_q == PXW'(CELL_W - 1));
		row_last     = (grow_q == RW'(CELL_H - 1));
		cell_end     = px_last && row_last;
		scroll_after = wrap_col && !row_adv;
	end

	// Pixel colour: glyph pixels, then a background column; the last row is background.
	always_comb begin
		row_bits = (grow_q == RW'(GROWS)) ? '0 : gm_rdata;
		bit_idx  = PXW'(CELL_W - 2) - px_q;
		lit      = !px_last && row_bits[bit_idx];
	end

	// Glyph read address: prefetch the next row while the last pixel of a row leaves.
	always_comb begin
		rd_row = grow_q;
		if (pix_fire && px_last && !row_last) begin
			rd_row = grow_q + RW'(1);
		end
		if (rd_row >= RW'(GROWS)) begin
			rd_row = RW'(GROWS - 1);
		end
		gm_raddr = gbase_q + AW'(rd_row);
	end

	// Glyph number for a drawn byte; anything unprintable draws a space.
	always_comb begin
		if (in_char < CODE_PRINT_FIRST || in_char > CODE_PRINT_LAST) begin
			draw_glyph = 8'd0;
		end else begin
			draw_glyph = in_char - CODE_PRINT_FIRST;
		end
		if (int'(draw_glyph) >= GLYPH_COUNT) begin
			draw_glyph = 8'd0;
		end
		load_ok = (int'(in_gi) < GLYPH_COUNT) && (int'(in_gr) < GROWS);
	end

	// Glyph store write.
	always_comb begin
		gm_we    = (state_q == ST_GWRITE);
		gm_waddr = result[AW-1:0] + AW'(gr_q);
		gm_wdata = GW'(gb_q);
	end

	// Text bytes go to the colour unit, which ignores what is not its own.
	always_comb begin
		ccmd.en   = accept && !s_tuser;
		ccmd.code = in_char;
	end

	// Operand selection for the shared unit.
	always_comb begin
		areq.en = 1'b1;
		areq.op = OP_ADD;
		areq.a  = '0;
		areq.b  = '0;
		case (state_q)
			ST_GLOAD: begin
				areq.op = OP_MUL;
				areq.a  = 32'(gi_q);
				areq.b  = 32'(GROWS);
			end
			ST_MGLYPH: begin
				areq.op = OP_MUL;
				areq.a  = 32'(glyph_q);
				areq.b  = 32'(GROWS);
			end
			ST_MCOL: begin
				areq.op = OP_MUL;
				areq.a  = 32'(col_q);
				areq.b  = 32'(2 * CELL_W);
			end
			ST_MROW: begin
				areq.op = OP_MUL;
				areq.a  = 32'(row_q);
				areq.b  = 32'(CELL_H);
			end
			ST_MPITCH: begin
				areq.op = OP_MUL;
				areq.a  = result;
				areq.b  = 32'(cfg.line_pitch);
			end
			ST_ABASE: begin
				areq.a = result;
				areq.b = cfg.screen_base;
			end
			ST_ACOL: begin
				areq.a = result;
				areq.b = 32'(col_off_q);
			end
			ST_PIX: begin
				// Step along the row, or from the row start down one scan line.
				areq.en = load_out;
				areq.a  = px_last ? row_addr_q : result;
				areq.b  = px_last ? 32'(cfg.line_pitch) : 32'd2;
			end
			default: areq.en = 1'b0;
		endcase
	end

	// Sequencer, cursor and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			px_q       <= '0;
			grow_q     <= '0;
			glyph_q    <= '0;
			gi_q       <= '0;
			gr_q       <= '0;
			gb_q       <= '0;
			gbase_q    <= '0;
			col_off_q  <= '0;
			row_addr_q <= '0;
			m_tvalid_q <= 1'b0;
			m_kind_q   <= 1'b0;
			m_last_q   <= 1'b0;
			m_addr_q   <= '0;
			m_colour_q <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser) begin
							gi_q <= in_gi;
							gr_q <= in_gr;
							gb_q <= in_gb;
							if (load_ok) begin
								state_q <= ST_GLOAD;
							end
						end else begin
							case (code_kind(in_char))
								CK_NEWLINE: begin
									col_q <= '0;
									if (row_adv) begin
										row_q <= row_q + 10'd1;
									end else begin
										state_q <= ST_SCROLL;
									end
								end
								CK_DRAW: begin
									glyph_q <= draw_glyph;
									px_q    <= '0;
									grow_q  <= '0;
									state_q <= ST_MGLYPH;
								end
								default: ;
							endcase
						end
					end
				end
				ST_GLOAD:  state_q <= ST_GWRITE;
				ST_GWRITE: state_q <= ST_IDLE;
				ST_MGLYPH: state_q <= ST_MCOL;
				ST_MCOL: begin
					gbase_q <= result[AW-1:0];
					state_q <= ST_MROW;
				end
				ST_MROW: begin
					col_off_q <= result[15:0];
					state_q   <= ST_MPITCH;
				end
				ST_MPITCH: state_q <= ST_ABASE;
				ST_ABASE:  state_q <= ST_ACOL;
				ST_ACOL:   state_q <= ST_PIX;
				ST_PIX: begin
					if (load_out) begin
						m_tvalid_q <= 1'b1;
						m_kind_q   <= 1'b0;
						m_addr_q   <= result;
						m_colour_q <= lit ? fore : back;
						m_last_q   <= cell_end && !scroll_after;
						if (px_q == '0) begin
							row_addr_q <= result;
						end
						if (px_last) begin
							px_q   <= '0;
							grow_q <= row_last ? '0 : grow_q + RW'(1);
						end else begin
							px_q <= px_q + PXW'(1);
						end
						// Advance the cursor once the cell is out.
						if (cell_end) begin
							state_q <= ST_IDLE;
							if (wrap_col) begin
								col_q <= '0;
								if (row_adv) begin
									row_q <= row_q + 10'd1;
								end else begin
									state_q <= ST_SCROLL;
								end
							end else begin
								col_q <= col_inc;
							end
						end
					end
				end
				ST_SCROLL: begin
					if (load_out) begin
						m_tvalid_q <= 1'b1;
						m_kind_q   <= 1'b1;
						m_addr_q   <= cfg.screen_base;
						m_colour_q <= '0;
						m_last_q   <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_colour_q, m_addr_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_kind_q;

endmodule

// ===== rtl/core/text_console_renderer_top.sv =====
// Top level of the text console renderer: configuration registers and unit wiring.
// Depends on tcr_pkg, tcr_arith, tcr_glyph_mem, tcr_colour and tcr_seq.
//
// Usage:
//   Input stream (s_axis_*): one beat per item. tuser = 1 loads one glyph row,
//   tuser = 0 carries a text byte. A text byte either changes colours, the colour
//   stack or the cursor, or draws one CELL_W x CELL_H character cell.
//   Output stream (m_axis_*): pixel writes (tuser = 0) with byte address and
//   RGB565 colour, and scroll requests (tuser = 1) carrying screen_base.
//   tlast marks the final beat caused by one input item.
//   A drawn character first sets up its address on the shared multiply/add unit
//   (ST_MGLYPH, ST_MCOL, ST_MROW, ST_MPITCH, ST_ABASE, ST_ACOL), then writes one
//   pixel per cycle while the sink is ready, CELL_W*CELL_H beats (60), plus one
//   beat for a scroll. A glyph load passes ST_GLOAD and ST_GWRITE and is dropped
//   when its index or row is out of range; a new line that scrolls passes
//   ST_SCROLL to send the scroll request.
//   The input is not ready while a cell is being walked.
//   A stalled sink holds the output register and the sequencer with it;
//   the next item may be accepted while the last result still waits.
//   Reset sets the cursor to the top left, white on black, an empty colour stack
//   and default registers; the glyph store holds no defined contents until it is
//   loaded. Write registers only while the block is idle; it does not enforce it.
module text_console_renderer_top import tcr_pkg::*; #(
	parameter int CELL_W      = CELL_W_DEF,
	parameter int CELL_H      = CELL_H_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Fields from bit 0: char_code[7:0], glyph_index[14:8], glyph_row[18:15],
	// glyph_bits[23:19].
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// Fields from bit 0: cmd.
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// Fields from bit 0: address[31:0], colour[47:32].
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	// Fields from bit 0: kind.
	output logic                  m_axis_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int GROWS = CELL_H - 1;
	localparam int STORE = GLYPH_COUNT * GROWS;
	localparam int AW    = $clog2(STORE);
	localparam int GW    = CELL_W - 1;

	cfg_t        cfg_q;
	arith_req_t  areq;
	logic [31:0] result;
	colour_cmd_t ccmd;
	logic [15:0] fore;
	logic [15:0] back;
	logic          gm_we;
	logic [AW-1:0] gm_waddr;
	logic [GW-1:0] gm_wdata;
	logic [AW-1:0] gm_raddr;
	logic [GW-1:0] gm_rdata;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_base   <= 32'd0;
			cfg_q.line_pitch    <= 16'd1280;
			cfg_q.max_columns   <= 10'd106;
			cfg_q.max_text_rows <= 10'd48;
			cfg_q.half_mask     <= 16'd31727;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_BASE:   cfg_q.screen_base   <= cfg_data;
				REG_LINE_PITCH:    cfg_q.line_pitch    <= cfg_data[15:0];
				REG_MAX_COLUMNS:   cfg_q.max_columns   <= cfg_data[9:0];
				REG_MAX_TEXT_ROWS: cfg_q.max_text_rows <= cfg_data[9:0];
				REG_HALF_MASK:     cfg_q.half_mask     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	tcr_arith u_arith (
		.clk    (clk),
		.req    (areq),
		.result (result)
	);

	tcr_glyph_mem #(
		.DEPTH (STORE),
		.DW    (GW)
	) u_glyph_mem (
		.clk   (clk),
		.we    (gm_we),
		.waddr (gm_waddr),
		.wdata (gm_wdata),
		.raddr (gm_raddr),
		.rdata (gm_rdata)
	);

	tcr_colour #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_colour (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ccmd),
		.half_mask (cfg_q.half_mask),
		.fore      (fore),
		.back      (back)
	);

	tcr_seq #(
		.CELL_W      (CELL_W),
		.CELL_H      (CELL_H),
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast),
		.m_tuser  (m_axis_tuser),
		.areq     (areq),
		.result   (result),
		.gm_we    (gm_we),
		.gm_waddr (gm_waddr),
		.gm_wdata (gm_wdata),
		.gm_raddr (gm_raddr),
		.gm_rdata (gm_rdata),
		.ccmd     (ccmd),
		.fore     (fore),
		.back     (back)
	);

`ifndef SYNTHESIS
	// A scroll request always closes its item and carries no colour.
	a_scroll_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[47:32] == 16'd0))
		else $error("scroll beat without tlast or with a colour");

	// While a beat that is not the last one waits, the block is still busy.
	a_busy_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready while an item is still producing beats");

	// A drawn byte keeps the input closed in the next cycle.
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser
			&& (code_kind(s_axis_tdata[7:0]) == CK_DRAW)
		|=> !s_axis_tready)
		else $error("input ready right after a draw");
`endif

endmodule
